// File: sv/ltn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltn_pkg
// shared constants and control types for the level-order tree navigator
// ----------------------------------------------------------------------------
package ltn_pkg;

   localparam int MAX_NODES   = 256;
   localparam int LABEL_BITS  = 16;
   localparam int SEQ_DEPTH   = 2 * MAX_NODES + 1;
   localparam int IDX_W       = $clog2(SEQ_DEPTH);
   localparam int POS_W       = 10;
   localparam int NODE_W      = 9;
   localparam int LABEL_W     = 16;
   localparam int DEG_W       = 9;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic REQ_WRITE      = 1'b0;
   localparam logic REQ_QUERY      = 1'b1;
   localparam logic CSR_NODE_COUNT = 1'b0;

   typedef struct packed {
      logic capture;
      logic mem_write;
      logic rd_x;
      logic chk_x;
      logic scan1_start;
      logic scan2_start;
      logic scan_run;
      logic scan2;
      logic emit_write;
      logic emit_query;
      logic emit_error;
   } ltn_cmd_type;

   typedef struct packed {
      logic x_bad;
      logic scan_done;
      logic out_free;
   } ltn_sts_type;

endpackage

// File: sv/ltn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltn_if
// request and response channels of the tree navigator
// ----------------------------------------------------------------------------
interface ltn_req_if import ltn_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [POS_W-1:0]   position;
   logic               entry_bit;
   logic [LABEL_W-1:0] entry_label;

   modport source (output valid, output req_type, output position, output entry_bit,
                   output entry_label, input ready);
   modport sink   (input valid, input req_type, input position, input entry_bit,
                   input entry_label, output ready);
endinterface

interface ltn_rsp_if import ltn_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LABEL_W-1:0] node_label;
   logic               parent_valid;
   logic [POS_W-1:0]   parent_pos;
   logic               first_child_valid;
   logic [POS_W-1:0]   first_child_pos;
   logic               last_child_valid;
   logic [POS_W-1:0]   last_child_pos;
   logic               sibling_valid;
   logic [POS_W-1:0]   sibling_pos;
   logic [DEG_W-1:0]   child_degree;
   logic               query_error;

   modport source (output valid, output node_label, output parent_valid, output parent_pos,
                   output first_child_valid, output first_child_pos,
                   output last_child_valid, output last_child_pos,
                   output sibling_valid, output sibling_pos, output child_degree,
                   output query_error, input ready);
   modport sink   (input valid, input node_label, input parent_valid, input parent_pos,
                   input first_child_valid, input first_child_pos,
                   input last_child_valid, input last_child_pos,
                   input sibling_valid, input sibling_pos, input child_degree,
                   input query_error, output ready);
endinterface

// File: sv/louds_tree_navigation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// louds_tree_navigation
// level-order unary degree sequence store with parent/child/sibling lookup
// ----------------------------------------------------------------------------
// req_bus carries one transaction per item: req_type 0 writes entry_bit and
// entry_label at position, req_type 1 queries the node whose 1 bit sits at
// position. rsp_bus returns exactly one transaction per request; writes give
// an all-zero response. node_count is set over the csr_ apb port (offset 0);
// the user must do this only while the block is idle (not enforced). the
// sequence length is 2*node_count+1, node_count 0 read as 1, capped at 256.
// a query runs one rank scan over positions 0..x and one select scan over
// 0..L-1 for query position x and length L, one stored bit per cycle through
// the single read port of the sequence store. a query on a 0 bit or at or
// beyond L goes from the check state to the error state and returns with
// query_error set. one request is in flight at a time; a response held in the
// output register while rsp_bus.ready is low does not block the next request
// from being accepted, only its completion. reset clears control state and
// sets node_count to 1; the stores hold nothing defined until written.
// ----------------------------------------------------------------------------
module louds_tree_navigation import ltn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ltn_req_if.sink               req_bus,
   ltn_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [NODE_W-1:0] node_count_ff;
   logic [NODE_W-1:0] node_sat;
   logic [POS_W-1:0]  seq_len;
   logic              csr_wr;
   ltn_cmd_type       cmd;
   ltn_sts_type       sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_W'(1);
      end else if (csr_wr && (csr_paddr[2] == CSR_NODE_COUNT)) begin
         node_count_ff <= csr_pwdata[NODE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_NODE_COUNT) ?
                       CSR_DATA_W'(node_count_ff) : '0;

   always_comb begin
      node_sat = node_count_ff;
      if (node_count_ff == '0) begin
         node_sat = NODE_W'(1);
      end else if (node_count_ff > NODE_W'(MAX_NODES)) begin
         node_sat = NODE_W'(MAX_NODES);
      end
   end

   assign seq_len = {node_sat, 1'b1};

   ltn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ltn_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .seq_len               (seq_len),
      .in_position           (req_bus.position),
      .in_entry_bit          (req_bus.entry_bit),
      .in_entry_label        (req_bus.entry_label),
      .out_ready             (rsp_bus.ready),
      .out_valid             (rsp_bus.valid),
      .out_node_label        (rsp_bus.node_label),
      .out_parent_valid      (rsp_bus.parent_valid),
      .out_parent_pos        (rsp_bus.parent_pos),
      .out_first_child_valid (rsp_bus.first_child_valid),
      .out_first_child_pos   (rsp_bus.first_child_pos),
      .out_last_child_valid  (rsp_bus.last_child_valid),
      .out_last_child_pos    (rsp_bus.last_child_pos),
      .out_sibling_valid     (rsp_bus.sibling_valid),
      .out_sibling_pos       (rsp_bus.sibling_pos),
      .out_child_degree      (rsp_bus.child_degree),
      .out_query_error       (rsp_bus.query_error)
   );

endmodule

// File: sv/ltn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltn_ctrl
// sequencer: write, position check, rank scan, select scan, result hand-off
// ----------------------------------------------------------------------------
module ltn_ctrl import ltn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_type,
   output logic        req_ready,
   input  ltn_sts_type sts,
   output ltn_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WRITE = 3'd1;
   localparam logic [2:0] ST_QRD   = 3'd2;
   localparam logic [2:0] ST_QCHK  = 3'd3;
   localparam logic [2:0] ST_SCAN1 = 3'd4;
   localparam logic [2:0] ST_SCAN2 = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;
   localparam logic [2:0] ST_ERR   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_type == REQ_QUERY) ? ST_QRD : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            if (sts.out_free) begin
               cmd.emit_write = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_QRD: begin
            cmd.rd_x = 1'b1;
            state_in = ST_QCHK;
         end
         ST_QCHK: begin
            cmd.chk_x = 1'b1;
            if (sts.x_bad) begin
               state_in = ST_ERR;
            end else begin
               cmd.scan1_start = 1'b1;
               state_in        = ST_SCAN1;
            end
         end
         ST_SCAN1: begin
            if (sts.scan_done) begin
               cmd.scan2_start = 1'b1;
               state_in        = ST_SCAN2;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_SCAN2: begin
            if (sts.scan_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_run = 1'b1;
               cmd.scan2    = 1'b1;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit_query = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (sts.out_free) begin
               cmd.emit_error = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/ltn_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltn_dpath
// sequence stores, rank/select scan counters and the response register
// ----------------------------------------------------------------------------
module ltn_dpath import ltn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ltn_cmd_type        cmd,
   output ltn_sts_type        sts,
   input  logic [POS_W-1:0]   seq_len,
   input  logic [POS_W-1:0]   in_position,
   input  logic               in_entry_bit,
   input  logic [LABEL_W-1:0] in_entry_label,
   input  logic               out_ready,
   output logic               out_valid,
   output logic [LABEL_W-1:0] out_node_label,
   output logic               out_parent_valid,
   output logic [POS_W-1:0]   out_parent_pos,
   output logic               out_first_child_valid,
   output logic [POS_W-1:0]   out_first_child_pos,
   output logic               out_last_child_valid,
   output logic [POS_W-1:0]   out_last_child_pos,
   output logic               out_sibling_valid,
   output logic [POS_W-1:0]   out_sibling_pos,
   output logic [DEG_W-1:0]   out_child_degree,
   output logic               out_query_error
);

   logic                  bit_mem   [SEQ_DEPTH];
   logic [LABEL_BITS-1:0] label_mem [SEQ_DEPTH];

   logic [POS_W-1:0]      x_ff;
   logic                  wbit_ff;
   logic [LABEL_BITS-1:0] wlabel_ff;
   logic                  bit_rd_ff;
   logic [LABEL_BITS-1:0] label_rd_ff;
   logic [LABEL_BITS-1:0] label_x_ff;
   logic [IDX_W-1:0]      rd_addr;

   logic [POS_W-1:0]      idx_ff;
   logic [POS_W-1:0]      lim_ff;
   logic                  pend_ff;
   logic [POS_W-1:0]      pidx_ff;
   logic [POS_W-1:0]      ones_ff;
   logic [POS_W-1:0]      zeros_ff;
   logic [POS_W-1:0]      r0_ff;
   logic [POS_W-1:0]      r1_ff;
   logic                  prev_ff;
   logic                  fpend_ff;
   logic                  pv_ff;
   logic                  fv_ff;
   logic                  lv_ff;
   logic                  sv_ff;
   logic [POS_W-1:0]      par_ff;
   logic [POS_W-1:0]      first_ff;
   logic [POS_W-1:0]      last_ff;

   logic                  issue;
   logic                  b;
   logic [POS_W-1:0]      ones_nx;
   logic [POS_W-1:0]      zeros_nx;
   logic [POS_W-1:0]      x_next;
   logic [POS_W-1:0]      deg_full;
   logic                  deg_ok;

   assign rd_addr  = cmd.rd_x ? x_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign issue    = (idx_ff <= lim_ff);
   assign b        = bit_rd_ff;
   assign ones_nx  = ones_ff + POS_W'(1);
   assign zeros_nx = zeros_ff + POS_W'(1);
   assign x_next   = x_ff + POS_W'(1);
   assign deg_full = last_ff - first_ff + POS_W'(1);
   assign deg_ok   = fv_ff && lv_ff && (last_ff >= first_ff);

   assign sts.x_bad     = (x_ff >= seq_len) || !bit_rd_ff;
   assign sts.scan_done = !pend_ff && !issue;
   assign sts.out_free  = !out_valid || out_ready;

   // sequence stores
   always_ff @(posedge clock) begin
      if (cmd.mem_write && (x_ff < POS_W'(SEQ_DEPTH))) begin
         bit_mem[x_ff[IDX_W-1:0]]   <= wbit_ff;
         label_mem[x_ff[IDX_W-1:0]] <= wlabel_ff;
      end
      bit_rd_ff   <= bit_mem[rd_addr];
      label_rd_ff <= label_mem[rd_addr];
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff      <= in_position;
         wbit_ff   <= in_entry_bit;
         wlabel_ff <= in_entry_label[LABEL_BITS-1:0];
      end
      if (cmd.chk_x) begin
         label_x_ff <= label_rd_ff;
      end
   end

   // rank and select scans
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         idx_ff  <= '0;
         lim_ff  <= '0;
      end else if (cmd.scan1_start || cmd.scan2_start) begin
         pend_ff <= 1'b0;
         idx_ff  <= '0;
         lim_ff  <= cmd.scan1_start ? x_ff : seq_len - POS_W'(1);
      end else if (cmd.scan_run) begin
         pend_ff <= issue;
         if (issue) begin
            idx_ff <= idx_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= idx_ff;
      if (cmd.scan1_start || cmd.scan2_start) begin
         ones_ff  <= '0;
         zeros_ff <= '0;
      end else if (pend_ff) begin
         if (b) begin
            ones_ff <= ones_nx;
         end else begin
            zeros_ff <= zeros_nx;
         end
      end
      if (cmd.scan2_start) begin
         r0_ff    <= zeros_ff;
         r1_ff    <= ones_ff;
         fpend_ff <= (ones_ff == '0);
         prev_ff  <= 1'b0;
         pv_ff    <= 1'b0;
         fv_ff    <= 1'b0;
         lv_ff    <= 1'b0;
         sv_ff    <= 1'b0;
      end else if (pend_ff && cmd.scan2) begin
         prev_ff <= b;
         if (b && (r0_ff != '0) && (ones_nx == r0_ff)) begin
            pv_ff  <= 1'b1;
            par_ff <= pidx_ff;
         end
         if (fpend_ff) begin
            fv_ff    <= b;
            first_ff <= pidx_ff;
            fpend_ff <= 1'b0;
         end
         if (!b && (zeros_nx == r1_ff)) begin
            fpend_ff <= 1'b1;
         end
         if (!b && (zeros_nx == r1_ff + POS_W'(1)) && (pidx_ff != '0)) begin
            lv_ff   <= prev_ff;
            last_ff <= pidx_ff - POS_W'(1);
         end
         if (pidx_ff == x_next) begin
            sv_ff <= b;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (cmd.emit_write || cmd.emit_query || cmd.emit_error) begin
         out_valid <= 1'b1;
      end else if (out_ready) begin
         out_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_write || cmd.emit_error) begin
         out_node_label        <= '0;
         out_parent_valid      <= 1'b0;
         out_parent_pos        <= '0;
         out_first_child_valid <= 1'b0;
         out_first_child_pos   <= '0;
         out_last_child_valid  <= 1'b0;
         out_last_child_pos    <= '0;
         out_sibling_valid     <= 1'b0;
         out_sibling_pos       <= '0;
         out_child_degree      <= '0;
         out_query_error       <= cmd.emit_error;
      end else if (cmd.emit_query) begin
         out_node_label        <= LABEL_W'(label_x_ff);
         out_parent_valid      <= pv_ff;
         out_parent_pos        <= pv_ff ? par_ff : '0;
         out_first_child_valid <= fv_ff;
         out_first_child_pos   <= fv_ff ? first_ff : '0;
         out_last_child_valid  <= lv_ff;
         out_last_child_pos    <= lv_ff ? last_ff : '0;
         out_sibling_valid     <= sv_ff;
         out_sibling_pos       <= sv_ff ? x_next : '0;
         out_child_degree      <= deg_ok ? deg_full[DEG_W-1:0] : '0;
         out_query_error       <= 1'b0;
      end
   end

endmodule
